// ===== sv/u8sd_pkg.sv =====
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Byte classes decided by the front
  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_ASCII = 3'd0;
  localparam logic [CLS_W-1:0] CLS_CONT  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_LEAD2 = 3'd2;
  localparam logic [CLS_W-1:0] CLS_LEAD3 = 3'd3;
  localparam logic [CLS_W-1:0] CLS_LEAD4 = 3'd4;
  localparam logic [CLS_W-1:0] CLS_BAD   = 3'd5;

  typedef logic [CLS_W-1:0] cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [BYTE_W-1:0] data;
  } q_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/u8sd_if.sv =====
// u8sd_if: valid/ready channel interfaces for input bytes and decoded words.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

interface u8sd_byte_if;
  import u8sd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8sd_cp_if;
  import u8sd_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] codepoint;
  logic            is_error;
  modport source (output valid, output codepoint, output is_error, input ready);
  modport sink   (input valid, input codepoint, input is_error, output ready);
endinterface

// ===== sv/u8sd_front.sv =====
// u8sd_front: accepts input bytes and tags each one with its byte class.
// Depends on u8sd_pkg and u8sd_byte_if.
`timescale 1ns / 1ps

module u8sd_front (
  u8sd_byte_if.sink            in_ch,
  input  u8sd_pkg::q_status_t  q_stat,
  output logic                 push,
  output u8sd_pkg::q_item_t    push_item
);
  import u8sd_pkg::*;

  cls_t cls;

  always_comb begin
    case (in_ch.in_byte) inside
      [8'h00:8'h7F]: cls = CLS_ASCII;
      [8'h80:8'hBF]: cls = CLS_CONT;
      [8'hC0:8'hDF]: cls = CLS_LEAD2;
      [8'hE0:8'hEF]: cls = CLS_LEAD3;
      [8'hF0:8'hF7]: cls = CLS_LEAD4;
      default:       cls = CLS_BAD;
    endcase
  end

  assign in_ch.ready    = !q_stat.full;
  assign push           = in_ch.valid && !q_stat.full;
  assign push_item.cls  = cls;
  assign push_item.data = in_ch.in_byte;

endmodule

// ===== sv/u8sd_queue.sv =====
// u8sd_queue: small register FIFO of classified bytes between front and back.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8sd_pkg::q_item_t   push_item,
  input  logic                pop,
  output u8sd_pkg::q_item_t   pop_item,
  output u8sd_pkg::q_status_t q_stat
);
  import u8sd_pkg::*;

  q_item_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/u8sd_back.sv =====
// u8sd_back: sequence decoder; pops classified bytes, builds codepoints and
// holds each result in an output register. Depends on u8sd_pkg, u8sd_cp_if.
`timescale 1ns / 1ps

module u8sd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u8sd_pkg::q_item_t   pop_item,
  input  u8sd_pkg::q_status_t q_stat,
  output logic                pop,
  u8sd_cp_if.source           out_ch
);
  import u8sd_pkg::*;

  logic [1:0]      rem_r, rem_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic            err_r, err_nxt;
  logic            emit;
  logic [CP_W-1:0] shifted;

  // Pop whenever the output register is free or being drained this cycle
  assign pop     = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign shifted = {part_r[CP_W-7:0], pop_item.data[5:0]};

  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    emit     = 1'b0;
    cp_nxt   = cp_r;
    err_nxt  = err_r;
    if (pop) begin
      if (rem_r != 2'd0) begin
        if (pop_item.cls != CLS_CONT) begin
          // bad continuation: consumed, back to idle
          rem_nxt  = 2'd0;
          part_nxt = '0;
          emit     = 1'b1;
          cp_nxt   = '0;
          err_nxt  = 1'b1;
        end else if (rem_r == 2'd1) begin
          rem_nxt  = 2'd0;
          part_nxt = '0;
          emit     = 1'b1;
          cp_nxt   = shifted;
          err_nxt  = 1'b0;
        end else begin
          rem_nxt  = rem_r - 2'd1;
          part_nxt = shifted;
        end
      end else begin
        case (pop_item.cls)
          CLS_ASCII: begin
            emit    = 1'b1;
            cp_nxt  = CP_W'(pop_item.data);
            err_nxt = 1'b0;
          end
          CLS_LEAD2: begin
            rem_nxt  = 2'd1;
            part_nxt = CP_W'(pop_item.data[4:0]);
          end
          CLS_LEAD3: begin
            rem_nxt  = 2'd2;
            part_nxt = CP_W'(pop_item.data[3:0]);
          end
          CLS_LEAD4: begin
            rem_nxt  = 2'd3;
            part_nxt = CP_W'(pop_item.data[2:0]);
          end
          default: begin
            // stray continuation or invalid lead
            emit    = 1'b1;
            cp_nxt  = '0;
            err_nxt = 1'b1;
          end
        endcase
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 2'd0;
      part_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    err_r <= err_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.codepoint = cp_r;
  assign out_ch.is_error  = err_r;

endmodule

// ===== sv/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder, top level: front classifier, 4-entry queue, decoder back.
// A byte that completes a result passes through the queue register, then the output register, to out_ch.
// Throughput: one byte per cycle while the queue is not full; the back stops popping while out_ch stalls.
// Reset (rst_n low, synchronous): queue emptied, decoder idle, no result pending.
// Depends on u8sd_pkg, u8sd_if, u8sd_front, u8sd_queue, u8sd_back.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit (
  input logic       clk,
  input logic       rst_n,
  u8sd_byte_if.sink in_ch,
  u8sd_cp_if.source out_ch
);
  import u8sd_pkg::*;

  q_status_t q_stat;
  q_item_t   push_item;
  q_item_t   pop_item;
  logic      push;
  logic      pop;

  u8sd_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  u8sd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  u8sd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_item (pop_item),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== sv/u8sd_checker.sv =====
// u8sd_checker: port-level assertions for utf8_stream_decoder_unit, with bind.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [u8sd_pkg::CP_W-1:0] out_codepoint,
  input logic                      out_is_error
);
  import u8sd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |-> out_codepoint == '0)
    else $error("error word carries nonzero codepoint");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_codepoint (out_ch.codepoint),
  .out_is_error  (out_ch.is_error)
);

// ===== tb/u8sd_decode_checker.sv =====
// u8sd_decode_checker: watches both channels of the UTF-8 stream decoder,
// predicts each decoded word from accepted bytes and compares in order.
// Depends on u8sd_pkg and u8sd_if.
`timescale 1ns / 1ps

module u8sd_decode_checker (
  input  logic clk,
  input  logic rst_n,
  u8sd_byte_if byte_mon,
  u8sd_cp_if   cp_mon,
  output int   fail_count,
  output int   words_pending
);
  import u8sd_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic            is_error;
  } cp_word_t;

  // Predictor state: continuation bytes still due and accumulated payload
  logic [1:0]      conts_due;
  logic [CP_W-1:0] cp_accum;
  cp_word_t        expected_words[$];

  // Returns 1 when the byte completes a word (codepoint or error)
  function automatic logic decode_next_byte(input logic [BYTE_W-1:0] b, output cp_word_t w);
    w = '0;
    if (conts_due != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        // bad continuation: byte is consumed, back to idle
        conts_due = 2'd0;
        cp_accum  = '0;
        w.is_error = 1'b1;
        return 1'b1;
      end
      cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
      conts_due = conts_due - 2'd1;
      if (conts_due == 2'd0) begin
        w.codepoint = cp_accum;
        cp_accum = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (b[7] == 1'b0) begin
      w.codepoint = CP_W'(b);
      return 1'b1;
    end
    if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
      // stray continuation or lead of 0xF8 and above
      w.is_error = 1'b1;
      return 1'b1;
    end
    if (b[7:5] == 3'b110) begin
      cp_accum  = CP_W'(b[4:0]);
      conts_due = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_accum  = CP_W'(b[3:0]);
      conts_due = 2'd2;
    end else begin
      cp_accum  = CP_W'(b[2:0]);
      conts_due = 2'd3;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cp_word_t w;
    cp_word_t exp_w;
    if (!rst_n) begin
      conts_due = 2'd0;
      cp_accum  = '0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        if (decode_next_byte(byte_mon.in_byte, w))
          expected_words.push_back(w);
      end
      if (cp_mon.valid && cp_mon.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word codepoint %h is_error %b", $time,
                   cp_mon.codepoint, cp_mon.is_error);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (cp_mon.codepoint !== exp_w.codepoint || cp_mon.is_error !== exp_w.is_error) begin
            $display("%0t: word mismatch expected codepoint %h is_error %b, got %h %b",
                     $time, exp_w.codepoint, exp_w.is_error, cp_mon.codepoint,
                     cp_mon.is_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

// ===== tb/tb_utf8_stream_decoder_unit.sv =====
// tb_utf8_stream_decoder_unit: byte stimulus and verdict for the decoder.
// Depends on u8sd_pkg, u8sd_if, utf8_stream_decoder_unit, u8sd_decode_checker.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_unit;
  import u8sd_pkg::*;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   fail_count;
  int   words_pending;

  u8sd_byte_if byte_ch ();
  u8sd_cp_if   cp_ch ();

  utf8_stream_decoder_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (cp_ch)
  );

  u8sd_decode_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_mon      (byte_ch),
    .cp_mon        (cp_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // Edge values, single and multi-byte sequences, then broken ones
  logic [BYTE_W-1:0] directed_bytes[$] = '{
    8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
    8'hC0, 8'h80,
    8'hC2, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hC3, 8'h41,
    8'hE2, 8'hC3,
    8'hF0, 8'h90, 8'hFF
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk)
    cp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

  // Leaves valid high after the edge at which the byte was taken
  task automatic put_byte(input logic [BYTE_W-1:0] b);
    logic hit;
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do begin
      @(negedge clk);
      hit = byte_ch.ready;
      @(posedge clk);
    end while (!hit);
  endtask

  task automatic drain_words();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0)
      @(posedge clk);
  endtask

  // Mostly well-formed sequences with random payload; some noise and cut-short ones
  task automatic send_random(input int n_bytes);
    int                sent;
    int                len;
    int                n_good;
    int                kind;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] seq[$];
    sent = 0;
    while (sent < n_bytes) begin
      seq.delete();
      kind = $urandom_range(99);
      len  = $urandom_range(1, 4);
      if (kind < 10) begin
        seq.push_back(BYTE_W'($urandom_range(255)));
      end else begin
        case (len)
          1: seq.push_back(BYTE_W'($urandom_range(127)));
          2: seq.push_back(8'hC0 | BYTE_W'($urandom_range(31)));
          3: seq.push_back(8'hE0 | BYTE_W'($urandom_range(15)));
          default: seq.push_back(8'hF0 | BYTE_W'($urandom_range(7)));
        endcase
        n_good = len - 1;
        if (kind < 22 && len > 1)
          n_good = $urandom_range(len - 2);
        repeat (n_good)
          seq.push_back(8'h80 | BYTE_W'($urandom_range(63)));
        if (n_good < len - 1) begin
          do b = BYTE_W'($urandom_range(255)); while (b[7:6] == 2'b10);
          seq.push_back(b);
        end
      end
      foreach (seq[i])
        put_byte(seq[i]);
      sent += seq.size();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    tx_idle_pct = 18;
    rx_idle_pct = 50;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i])
      put_byte(directed_bytes[i]);
    drain_words();

    send_random(380);
    tx_idle_pct = 50;
    rx_idle_pct = 18;
    send_random(380);
    drain_words();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(390);

    drain_words();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
